### rtl/core/mma_pkg.sv
// Shared constants and types for the matrix multiply-accumulate block.
package mma_pkg;

  localparam int MAX_DIM = 8;
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int DIM_W   = 4;
  localparam int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DATA_W  = 16;
  localparam int PROD_W  = 2 * DATA_W;
  localparam int ACC_W   = 40;
  localparam int C_SHIFT = 12;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DIM);

  typedef struct packed {
    logic [DIM_W-1:0] dim;
  } cmd_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] c;
  } wr_t;

  typedef struct packed {
    logic [ADDR_W-1:0] a_addr;
    logic [ADDR_W-1:0] b_addr;
    logic [ADDR_W-1:0] c_addr;
  } rd_t;

  typedef struct packed {
    logic done;
  } back_stat_t;

endpackage

### rtl/core/mma_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/mma_front.sv
// Front end: dimension register, element loading and frame completion.
module mma_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_wr_en_i,
  input  logic [mma_pkg::DIM_W-1:0] cfg_wr_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [mma_pkg::DATA_W-1:0] a_value_i,
  input  logic [mma_pkg::DATA_W-1:0] b_value_i,
  input  logic [mma_pkg::DATA_W-1:0] c_value_i,
  output mma_pkg::wr_t              wr_o,
  output logic                      push_o,
  output mma_pkg::cmd_t             cmd_o,
  input  logic                      full_i,
  input  mma_pkg::back_stat_t       stat_i
);
  import mma_pkg::*;

  logic [DIM_W-1:0]   dim_q;
  logic [ADDR_W-1:0]  cnt_q;
  logic               busy_q;
  logic [DIM_W-1:0]   n;
  logic [2*DIM_W-1:0] sq;
  logic [ADDR_W:0]    total;
  logic [ADDR_W:0]    cnt_inc;
  logic               take;
  logic               complete;

  always_comb begin
    if (dim_q == '0) begin
      n = DIM_W'(1);
    end else if (dim_q > DIM_W'(MAX_DIM)) begin
      n = DIM_W'(MAX_DIM);
    end else begin
      n = dim_q;
    end
  end

  assign sq       = {{DIM_W{1'b0}}, n} * {{DIM_W{1'b0}}, n};
  assign total    = (ADDR_W+1)'(sq);
  assign cnt_inc  = {1'b0, cnt_q} + (ADDR_W+1)'(1);
  assign in_stall_o = busy_q || full_i;
  assign take     = in_valid_i && !in_stall_o;
  assign complete = take && (cnt_inc >= total);

  assign wr_o.en   = take;
  assign wr_o.addr = cnt_q;
  assign wr_o.a    = a_value_i;
  assign wr_o.b    = b_value_i;
  assign wr_o.c    = c_value_i;
  assign push_o    = complete;
  assign cmd_o.dim = n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q  <= DIM_RESET;
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      if (cfg_wr_en_i) begin
        dim_q <= cfg_wr_data_i;
      end
      if (complete) begin
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else begin
        if (take) begin
          cnt_q <= cnt_inc[ADDR_W-1:0];
        end
        if (stat_i.done) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

endmodule

### rtl/core/mma_cmd_fifo.sv
// Two-entry command queue between front and back.
module mma_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mma_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output mma_pkg::cmd_t cmd_o
);
  import mma_pkg::*;

  cmd_t       ent_q [2];
  logic       wptr_q;
  logic       rptr_q;
  logic [1:0] cnt_q;
  logic       do_push;
  logic       do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = ent_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wptr_q <= !wptr_q;
      end
      if (do_pop) begin
        rptr_q <= !rptr_q;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

### rtl/core/mma_back.sv
// Back end: sequences the dot products, MAC pipeline and result register.
module mma_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  input  mma_pkg::cmd_t               cmd_i,
  output logic                        pop_o,
  output mma_pkg::rd_t                rd_o,
  input  logic [mma_pkg::DATA_W-1:0]  a_rd_i,
  input  logic [mma_pkg::DATA_W-1:0]  b_rd_i,
  input  logic [mma_pkg::DATA_W-1:0]  c_rd_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [mma_pkg::ACC_W-1:0]   c_result_o,
  output logic                        last_result_o,
  output mma_pkg::back_stat_t         stat_o
);
  import mma_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_OUT
  } state_e;

  state_e            state_q;
  logic [DIM_W-1:0]  n_q;
  logic [IDX_W-1:0]  nm1_q;
  logic [IDX_W-1:0]  i_q;
  logic [IDX_W-1:0]  j_q;
  logic [IDX_W-1:0]  k_q;
  logic [ADDR_W-1:0] a_addr_q;
  logic [ADDR_W-1:0] b_addr_q;
  logic [ADDR_W-1:0] col_q;
  logic              out_valid_q;
  logic [ACC_W-1:0]  out_data_q;
  logic              out_last_q;
  logic              done_q;

  logic              v1_q, first1_q, last1_q;
  logic              v2_q, first2_q, last2_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [DATA_W-1:0] c2_q;
  logic [ACC_W-1:0]  acc_q;
  logic [ACC_W-1:0]  acc_base;
  logic [ACC_W-1:0]  acc_d;

  logic              issue;
  logic              k_last;
  logic              elem_last;
  logic [IDX_W-1:0]  i_next;
  logic [IDX_W-1:0]  j_next;
  logic [ADDR_W-1:0] col_next;
  logic [ADDR_W-1:0] n_ext;

  assign issue     = (state_q == ST_ISSUE);
  assign k_last    = (k_q == nm1_q);
  assign elem_last = (i_q == nm1_q) && (j_q == nm1_q);
  assign n_ext     = ADDR_W'(n_q);
  assign pop_o     = (state_q == ST_IDLE) && cmd_valid_i;

  assign rd_o.a_addr = a_addr_q;
  assign rd_o.b_addr = b_addr_q;
  assign rd_o.c_addr = col_q + ADDR_W'(i_q);

  always_comb begin
    if (i_q == nm1_q) begin
      i_next   = '0;
      j_next   = j_q + IDX_W'(1);
      col_next = col_q + n_ext;
    end else begin
      i_next   = i_q + IDX_W'(1);
      j_next   = j_q;
      col_next = col_q;
    end
  end

  assign acc_base = first2_q
                  ? {{(ACC_W-DATA_W-C_SHIFT){c2_q[DATA_W-1]}}, c2_q, {C_SHIFT{1'b0}}}
                  : acc_q;
  assign acc_d    = acc_base + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      first1_q <= 1'b0;
      last1_q  <= 1'b0;
      v2_q     <= 1'b0;
      first2_q <= 1'b0;
      last2_q  <= 1'b0;
    end else begin
      v1_q     <= issue;
      first1_q <= (k_q == '0);
      last1_q  <= k_last;
      v2_q     <= v1_q;
      first2_q <= first1_q;
      last2_q  <= last1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= $signed(a_rd_i) * $signed(b_rd_i);
    c2_q   <= c_rd_i;
    if (v2_q) begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      n_q         <= '0;
      nm1_q       <= '0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      a_addr_q    <= '0;
      b_addr_q    <= '0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_last_q  <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            n_q      <= cmd_i.dim;
            nm1_q    <= IDX_W'(cmd_i.dim - DIM_W'(1));
            i_q      <= '0;
            j_q      <= '0;
            k_q      <= '0;
            a_addr_q <= '0;
            b_addr_q <= '0;
            col_q    <= '0;
            state_q  <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          if (k_last) begin
            state_q <= ST_DRAIN;
          end else begin
            k_q      <= k_q + IDX_W'(1);
            a_addr_q <= a_addr_q + n_ext;
            b_addr_q <= b_addr_q + ADDR_W'(1);
          end
        end
        ST_DRAIN: begin
          if (v2_q && last2_q) begin
            out_data_q  <= acc_d;
            out_last_q  <= elem_last;
            out_valid_q <= 1'b1;
            state_q     <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            if (elem_last) begin
              done_q  <= 1'b1;
              state_q <= ST_IDLE;
            end else begin
              i_q      <= i_next;
              j_q      <= j_next;
              col_q    <= col_next;
              k_q      <= '0;
              a_addr_q <= ADDR_W'(i_next);
              b_addr_q <= col_next;
              state_q  <= ST_ISSUE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign c_result_o    = out_data_q;
  assign last_result_o = out_last_q;
  assign stat_o.done   = done_q;

endmodule

### rtl/core/matrix_multiply_accumulate_top.sv
// Top level of the matrix multiply-accumulate block: C = C + A*B.
//
//   channel  signals                         payload
//   input    in_valid_i / in_stall_o         a_value_i, b_value_i, c_value_i
//   output   out_valid_o / out_stall_i       c_result_o, last_result_o
//   config   cfg_wr_en_i                     cfg_wr_data_i (matrix_dim)
//
// Loading accepts one element per cycle while in_stall_o is low; n*n transactions
// fill a frame. Input then stalls while the back end computes: for each result
// the sequencer issues n store reads through the MAC pipeline (store read,
// product register, accumulator), then drains the sum into the result register for hand-off.
// Reset sets matrix_dim to 8 and empties the frame; stores need no clearing.
// Output stall holds the result register and pauses the sequencer.
module matrix_multiply_accumulate_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_wr_en_i,
  input  logic [mma_pkg::DIM_W-1:0]   cfg_wr_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [mma_pkg::DATA_W-1:0]  a_value_i,
  input  logic [mma_pkg::DATA_W-1:0]  b_value_i,
  input  logic [mma_pkg::DATA_W-1:0]  c_value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [mma_pkg::ACC_W-1:0]   c_result_o,
  output logic                        last_result_o
);
  import mma_pkg::*;

  wr_t              wr;
  rd_t              rd;
  cmd_t             cmd_push;
  cmd_t             cmd_pop;
  back_stat_t       stat;
  logic             push;
  logic             pop;
  logic             full;
  logic             cmd_valid;
  logic [DATA_W-1:0] a_rd;
  logic [DATA_W-1:0] b_rd;
  logic [DATA_W-1:0] c_rd;

  mma_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .a_value_i     (a_value_i),
    .b_value_i     (b_value_i),
    .c_value_i     (c_value_i),
    .wr_o          (wr),
    .push_o        (push),
    .cmd_o         (cmd_push),
    .full_i        (full),
    .stat_i        (stat)
  );

  mma_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_push),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (cmd_valid),
    .cmd_o   (cmd_pop)
  );

  mma_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_a_store (
    .clk_i   (clk_i),
    .we_i    (wr.en),
    .waddr_i (wr.addr),
    .wdata_i (wr.a),
    .raddr_i (rd.a_addr),
    .rdata_o (a_rd)
  );

  mma_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_b_store (
    .clk_i   (clk_i),
    .we_i    (wr.en),
    .waddr_i (wr.addr),
    .wdata_i (wr.b),
    .raddr_i (rd.b_addr),
    .rdata_o (b_rd)
  );

  mma_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_c_store (
    .clk_i   (clk_i),
    .we_i    (wr.en),
    .waddr_i (wr.addr),
    .wdata_i (wr.c),
    .raddr_i (rd.c_addr),
    .rdata_o (c_rd)
  );

  mma_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd_pop),
    .pop_o         (pop),
    .rd_o          (rd),
    .a_rd_i        (a_rd),
    .b_rd_i        (b_rd),
    .c_rd_i        (c_rd),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .c_result_o    (c_result_o),
    .last_result_o (last_result_o),
    .stat_o        (stat)
  );

endmodule
